// ===== rtl/tsf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsf_pkg
// Types and constants shared by the touch sample filter modules.
// ----------------------------------------------------------------------------
package tsf_pkg;

  localparam int unsigned CoordW = 12;
  localparam int unsigned PresW  = 13;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned IntvW  = 16;
  localparam int unsigned OrientW = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CoordW-1:0] FullScale = 12'hFFF;

  localparam logic [OrientW-1:0] OrientResetVal    = 2'd3;
  localparam logic [PresW-1:0]   ThresholdResetVal = 13'd200;
  localparam logic [IntvW-1:0]   IntervalResetVal  = 16'd3;
  localparam logic [TimeW-1:0]   LastTimeResetVal  = 32'h8000_0000;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgOrientation = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgThreshold   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMinInterval = 2'd2;

  // orientation codes
  localparam logic [OrientW-1:0] OrientSwapInvX = 2'd0;
  localparam logic [OrientW-1:0] OrientIdentity = 2'd1;
  localparam logic [OrientW-1:0] OrientSwapInvY = 2'd2;
  localparam logic [OrientW-1:0] OrientInvBoth  = 2'd3;

  typedef struct packed {
    logic [TimeW-1:0]  now_ms;
    logic [CoordW-1:0] pressure_one;
    logic [CoordW-1:0] pressure_two;
    logic [CoordW-1:0] x_first;
    logic [CoordW-1:0] y_first;
    logic [CoordW-1:0] x_second;
    logic [CoordW-1:0] y_second;
    logic [CoordW-1:0] x_third;
    logic [CoordW-1:0] y_third;
  } in_item_t;

  typedef struct packed {
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic [PresW-1:0]  pressure;
    logic              is_touched;
    logic              was_sampled;
  } out_item_t;

  typedef struct packed {
    logic [CoordW-1:0] first;
    logic [CoordW-1:0] second;
    logic [CoordW-1:0] third;
  } axis_samples_t;

endpackage

// ===== rtl/tsf_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsf_in_if
// Valid/ready channel carrying one set of touch conversions.
// ----------------------------------------------------------------------------
interface tsf_in_if;
  import tsf_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/tsf_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsf_out_if
// Valid/ready channel carrying one filtered touch result.
// ----------------------------------------------------------------------------
interface tsf_out_if;
  import tsf_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/tsf_axis_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsf_axis_lane
// One axis: mean of the closest pair among three samples.
// ----------------------------------------------------------------------------
module tsf_axis_lane (
  input  tsf_pkg::axis_samples_t     samples_i,
  output logic [tsf_pkg::CoordW-1:0] mean_o
);
  import tsf_pkg::*;

  logic [CoordW-1:0] d_ab, d_ac, d_bc;
  logic [CoordW:0]   sum_ab, sum_ac, sum_bc;
  logic              ab_wins, ac_wins;

  always_comb begin
    d_ab = (samples_i.first > samples_i.second) ? samples_i.first - samples_i.second
                                                : samples_i.second - samples_i.first;
    d_ac = (samples_i.first > samples_i.third) ? samples_i.first - samples_i.third
                                               : samples_i.third - samples_i.first;
    d_bc = (samples_i.second > samples_i.third) ? samples_i.second - samples_i.third
                                                : samples_i.third - samples_i.second;
    sum_ab = {1'b0, samples_i.first} + {1'b0, samples_i.second};
    sum_ac = {1'b0, samples_i.first} + {1'b0, samples_i.third};
    sum_bc = {1'b0, samples_i.second} + {1'b0, samples_i.third};
    // ties: first/second beats first/third beats second/third
    ab_wins = (d_ab <= d_ac) && (d_ab <= d_bc);
    ac_wins = (d_ac <= d_bc);
    if (ab_wins) begin
      mean_o = sum_ab[CoordW:1];
    end else if (ac_wins) begin
      mean_o = sum_ac[CoordW:1];
    end else begin
      mean_o = sum_bc[CoordW:1];
    end
  end

endmodule

// ===== rtl/tsf_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsf_merge
// Interval and pressure checks, rotation of the lane results, held state
// and configuration registers.
// ----------------------------------------------------------------------------
module tsf_merge (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tsf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tsf_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         step_i,
  input  logic [tsf_pkg::TimeW-1:0]    now_ms_i,
  input  logic [tsf_pkg::CoordW-1:0]   z1_i,
  input  logic [tsf_pkg::CoordW-1:0]   z2_i,
  input  logic [tsf_pkg::CoordW-1:0]   mean_x_i,
  input  logic [tsf_pkg::CoordW-1:0]   mean_y_i,
  output tsf_pkg::out_item_t           result_o
);
  import tsf_pkg::*;

  logic [OrientW-1:0] orient_q;
  logic [PresW-1:0]   thresh_q;
  logic [IntvW-1:0]   intv_q;
  logic [CoordW-1:0]  held_x_q, held_x_d;
  logic [CoordW-1:0]  held_y_q, held_y_d;
  logic [PresW-1:0]   held_p_q, held_p_d;
  logic [TimeW-1:0]   last_t_q, last_t_d;

  logic [TimeW-1:0]  elapsed;
  logic              sampled;
  logic [PresW-1:0]  z;
  logic              touch;
  logic [CoordW-1:0] rot_x, rot_y;

  always_comb begin
    elapsed = now_ms_i - last_t_q;
    sampled = elapsed >= {{(TimeW-IntvW){1'b0}}, intv_q};
    // Z1 + 4095 - Z2 stays within 0..8190
    z = {1'b0, z1_i} + {1'b0, FullScale} - {1'b0, z2_i};
    touch = sampled && (z >= thresh_q);

    case (orient_q)
      OrientSwapInvX: begin
        rot_x = ~mean_y_i;
        rot_y = mean_x_i;
      end
      OrientIdentity: begin
        rot_x = mean_x_i;
        rot_y = mean_y_i;
      end
      OrientSwapInvY: begin
        rot_x = mean_y_i;
        rot_y = ~mean_x_i;
      end
      default: begin
        rot_x = ~mean_x_i;
        rot_y = ~mean_y_i;
      end
    endcase

    held_x_d = touch ? rot_x : held_x_q;
    held_y_d = touch ? rot_y : held_y_q;
    last_t_d = touch ? now_ms_i : last_t_q;
    if (touch) begin
      held_p_d = z;
    end else if (sampled) begin
      held_p_d = '0;
    end else begin
      held_p_d = held_p_q;
    end

    result_o.pos_x       = held_x_d;
    result_o.pos_y       = held_y_d;
    result_o.pressure    = held_p_d;
    result_o.is_touched  = held_p_d >= thresh_q;
    result_o.was_sampled = sampled;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orient_q <= OrientResetVal;
      thresh_q <= ThresholdResetVal;
      intv_q   <= IntervalResetVal;
      held_x_q <= '0;
      held_y_q <= '0;
      held_p_q <= '0;
      last_t_q <= LastTimeResetVal;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgOrientation: orient_q <= cfg_data_i[OrientW-1:0];
          CfgThreshold:   thresh_q <= cfg_data_i[PresW-1:0];
          CfgMinInterval: intv_q   <= cfg_data_i[IntvW-1:0];
          default: ;
        endcase
      end
      if (step_i) begin
        held_x_q <= held_x_d;
        held_y_q <= held_y_d;
        held_p_q <= held_p_d;
        last_t_q <= last_t_d;
      end
    end
  end

endmodule

// ===== rtl/touch_sample_filter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_sample_filter_core
// Resistive touch sample filter: dead-time check, pressure threshold,
// best-two-of-three averaging per axis, screen rotation.
// ----------------------------------------------------------------------------
// One sample set is taken per cycle while input ready is high. Its result is
// registered into the output register, or into the skid register if the output
// is stalled. The whole step (interval compare, pressure add and compare, the
// two axis lanes and the rotation) sits in the single path from the input into
// the held-state registers, so a set depends on the state left by the one
// before it without bubbles. A two-entry output (result register plus skid
// register) keeps input ready high while one result waits; ready drops only
// when both are full. Configuration writes take effect on the next cycle.
module touch_sample_filter_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tsf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tsf_pkg::CfgDataW-1:0] cfg_data_i,
  tsf_in_if.sink                       in_i,
  tsf_out_if.source                    out_o
);
  import tsf_pkg::*;

  axis_samples_t     x_samples, y_samples;
  logic [CoordW-1:0] mean_x, mean_y;
  out_item_t         result;
  logic              accept;

  logic      out_valid_q, skid_valid_q;
  out_item_t out_data_q, skid_data_q;

  assign x_samples = '{first: in_i.data.x_first, second: in_i.data.x_second,
                       third: in_i.data.x_third};
  assign y_samples = '{first: in_i.data.y_first, second: in_i.data.y_second,
                       third: in_i.data.y_third};

  tsf_axis_lane u_lane_x (.samples_i(x_samples), .mean_o(mean_x));
  tsf_axis_lane u_lane_y (.samples_i(y_samples), .mean_o(mean_y));

  assign in_i.ready = !skid_valid_q;
  assign accept     = in_i.valid && in_i.ready;

  tsf_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (accept),
    .now_ms_i   (in_i.data.now_ms),
    .z1_i       (in_i.data.pressure_one),
    .z2_i       (in_i.data.pressure_two),
    .mean_x_i   (mean_x),
    .mean_y_i   (mean_y),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || out_o.ready) begin
        out_valid_q  <= skid_valid_q || accept;
        skid_valid_q <= 1'b0;
      end else if (accept) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_o.ready) begin
      out_data_q <= skid_valid_q ? skid_data_q : result;
    end else if (accept) begin
      skid_data_q <= result;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

// ===== rtl/tsf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsf_checker
// Port-level checks for the touch sample filter, bound to the top level.
// ----------------------------------------------------------------------------
module tsf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [tsf_pkg::PresW-1:0]   out_pressure_i,
  input logic                        out_touched_i
);
  import tsf_pkg::*;

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a transfer into a free output shows up next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (!out_valid_i || out_ready_i) |=> out_valid_i)
    else $error("accepted set produced no result");

  // backpressure only with a result pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with empty output");

  // a stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable({out_pressure_i, out_touched_i}))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_pressure_i != {PresW{1'b1}})
    else $error("pressure out of range");

endmodule

bind touch_sample_filter_core tsf_checker u_tsf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_pressure_i (out_o.data.pressure),
  .out_touched_i  (out_o.data.is_touched)
);
